### hdl/afbd_pkg.sv
// shared types, register map and helpers for the anchor-free box decoder
// no dependencies
package afbd_pkg;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WIDTH     = 2'd1;
  localparam logic [1:0] REG_HEIGHT    = 2'd2;
  localparam logic [1:0] REG_STAGES    = 2'd3;

  localparam logic [15:0] THRESHOLD_RESET = 16'd0;
  localparam logic [12:0] WIDTH_RESET     = 13'd1024;
  localparam logic [12:0] HEIGHT_RESET    = 13'd640;
  localparam logic [2:0]  STAGES_RESET    = 3'd5;

  localparam logic signed [31:0] COORD_MAX = 32'sd8388607;
  localparam logic signed [31:0] COORD_MIN = -32'sd8388608;

  typedef struct packed {
    logic [15:0] score_threshold;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [2:0]  stage_count;
  } cfg_t;

  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    logic signed [23:0] r;
    if (v > COORD_MAX) begin
      r = 24'sh7FFFFF;
    end else if (v < COORD_MIN) begin
      r = -24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

### hdl/afbd_pred_if.sv
// prediction channel: one grid cell per transfer
// no dependencies
interface afbd_pred_if;
  logic               valid;
  logic               ready;
  logic        [15:0] score;
  logic signed [15:0] dist_left;
  logic signed [15:0] dist_top;
  logic signed [15:0] dist_right;
  logic signed [15:0] dist_bottom;

  modport source (output valid, score, dist_left, dist_top, dist_right, dist_bottom,
                  input ready);
  modport sink   (input valid, score, dist_left, dist_top, dist_right, dist_bottom,
                  output ready);
endinterface

### hdl/afbd_box_if.sv
// box channel: one decoded cell result per transfer
// no dependencies
interface afbd_box_if;
  logic               valid;
  logic               ready;
  logic               box_valid;
  logic signed [23:0] edge_x1;
  logic signed [23:0] edge_y1;
  logic signed [23:0] edge_x2;
  logic signed [23:0] edge_y2;
  logic        [15:0] box_score;
  logic               frame_end;

  modport source (output valid, box_valid, edge_x1, edge_y1, edge_x2, edge_y2,
                  box_score, frame_end, input ready);
  modport sink   (input valid, box_valid, edge_x1, edge_y1, edge_x2, edge_y2,
                  box_score, frame_end, output ready);
endinterface

### hdl/anchor_free_box_decoder.sv
// anchor-free multi-stride box decoder, one result per grid cell
// each cell passes the input register, the edge arithmetic and the result register;
// one cell per cycle sustained while the box channel is ready
// synchronous active-high reset clears the grid counters and both stage
// valid flags and loads the register reset values
module anchor_free_box_decoder #(
  parameter int MAX_STAGES = 5,
  parameter int MAX_SIDE   = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [afbd_pkg::ADDR_W-1:0]  paddr,
  input  logic [afbd_pkg::DATA_W-1:0]  pwdata,
  output logic [afbd_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  afbd_pred_if.sink                    pred,
  afbd_box_if.source                   box
);

  localparam int CW = $clog2(MAX_SIDE / 8);

  afbd_pkg::cfg_t     cfg;

  logic               a_valid;
  logic        [15:0] a_score;
  logic signed [15:0] a_dl;
  logic signed [15:0] a_dt;
  logic signed [15:0] a_dr;
  logic signed [15:0] a_db;
  logic               a_adv;

  logic               o_valid;
  logic               o_ready;
  logic               o_box_valid;
  logic signed [23:0] o_x1;
  logic signed [23:0] o_y1;
  logic signed [23:0] o_x2;
  logic signed [23:0] o_y2;
  logic        [15:0] o_score;
  logic               o_frame_end;

  logic        [2:0]  g_shift;
  logic      [CW-1:0] g_col;
  logic      [CW-1:0] g_row;
  logic               g_last;
  logic               g_origin;

  logic               c_box_valid;
  logic signed [23:0] c_x1;
  logic signed [23:0] c_y1;
  logic signed [23:0] c_x2;
  logic signed [23:0] c_y2;
  logic        [15:0] c_score;

  afbd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  afbd_grid #(
    .MAX_STAGES (MAX_STAGES),
    .MAX_SIDE   (MAX_SIDE),
    .CW         (CW)
  ) u_grid (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .adv       (a_adv),
    .shift     (g_shift),
    .col       (g_col),
    .row       (g_row),
    .last      (g_last),
    .at_origin (g_origin)
  );

  afbd_calc #(
    .CW (CW)
  ) u_calc (
    .shift       (g_shift),
    .col         (g_col),
    .row         (g_row),
    .threshold   (cfg.score_threshold),
    .score       (a_score),
    .dist_left   (a_dl),
    .dist_top    (a_dt),
    .dist_right  (a_dr),
    .dist_bottom (a_db),
    .box_valid   (c_box_valid),
    .edge_x1     (c_x1),
    .edge_y1     (c_y1),
    .edge_x2     (c_x2),
    .edge_y2     (c_y2),
    .box_score   (c_score)
  );

  assign o_ready    = !o_valid || box.ready;
  assign a_adv      = a_valid && o_ready;
  assign pred.ready = !a_valid || o_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (pred.ready) begin
      a_valid <= pred.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pred.valid && pred.ready) begin
      a_score <= pred.score;
      a_dl    <= pred.dist_left;
      a_dt    <= pred.dist_top;
      a_dr    <= pred.dist_right;
      a_db    <= pred.dist_bottom;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_ready) begin
      o_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      o_box_valid <= c_box_valid;
      o_x1        <= c_x1;
      o_y1        <= c_y1;
      o_x2        <= c_x2;
      o_y2        <= c_y2;
      o_score     <= c_score;
      o_frame_end <= g_last;
    end
  end

  assign box.valid     = o_valid;
  assign box.box_valid = o_box_valid;
  assign box.edge_x1   = o_x1;
  assign box.edge_y1   = o_y1;
  assign box.edge_x2   = o_x2;
  assign box.edge_y2   = o_y2;
  assign box.box_score = o_score;
  assign box.frame_end = o_frame_end;

  a_rst_clears: assert property (@(posedge clk)
    $past(rst) |-> !a_valid && !o_valid)
    else $error("pipeline valid set right after reset");

  a_frame_wraps: assert property (@(posedge clk) disable iff (rst)
    a_adv && g_last |=> g_origin)
    else $error("grid walk not back at origin after frame end");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    o_valid && !o_box_valid |-> o_x1 == '0 && o_y1 == '0 && o_x2 == '0 &&
                                o_y2 == '0 && o_score == '0)
    else $error("rejected cell carries nonzero box");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    a_valid && !o_ready |=> a_valid && $stable(a_score))
    else $error("input register lost an item while stalled");

endmodule

### hdl/afbd_cfg.sv
// apb configuration registers of the box decoder
// depends on afbd_pkg
module afbd_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [afbd_pkg::ADDR_W-1:0]  paddr,
  input  logic [afbd_pkg::DATA_W-1:0]  pwdata,
  output logic [afbd_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output afbd_pkg::cfg_t               cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.score_threshold <= afbd_pkg::THRESHOLD_RESET;
      cfg.image_width     <= afbd_pkg::WIDTH_RESET;
      cfg.image_height    <= afbd_pkg::HEIGHT_RESET;
      cfg.stage_count     <= afbd_pkg::STAGES_RESET;
    end else if (wr) begin
      unique case (paddr[3:2])
        afbd_pkg::REG_THRESHOLD: cfg.score_threshold <= pwdata[15:0];
        afbd_pkg::REG_WIDTH:     cfg.image_width     <= pwdata[12:0];
        afbd_pkg::REG_HEIGHT:    cfg.image_height    <= pwdata[12:0];
        afbd_pkg::REG_STAGES:    cfg.stage_count     <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      afbd_pkg::REG_THRESHOLD: prdata = {16'd0, cfg.score_threshold};
      afbd_pkg::REG_WIDTH:     prdata = {19'd0, cfg.image_width};
      afbd_pkg::REG_HEIGHT:    prdata = {19'd0, cfg.image_height};
      afbd_pkg::REG_STAGES:    prdata = {29'd0, cfg.stage_count};
      default:                 prdata = '0;
    endcase
  end

endmodule

### hdl/afbd_grid.sv
// stage, row and column walk over the multi-stride grids
// depends on afbd_pkg
module afbd_grid #(
  parameter int MAX_STAGES = 5,
  parameter int MAX_SIDE   = 4096,
  parameter int CW         = 9
) (
  input  logic           clk,
  input  logic           rst,
  input  afbd_pkg::cfg_t cfg,
  input  logic           adv,
  output logic [2:0]     shift,
  output logic [CW-1:0]  col,
  output logic [CW-1:0]  row,
  output logic           last,
  output logic           at_origin
);

  logic [2:0]    stage;
  logic [2:0]    stage_next;
  logic [CW-1:0] col_next;
  logic [CW-1:0] row_next;
  logic [2:0]    stage_eff;
  logic [2:0]    stages;
  logic [13:0]   w_side;
  logic [13:0]   h_side;
  logic [13:0]   stride;
  logic [13:0]   cols;
  logic [13:0]   rows;
  logic          col_wrap;
  logic          row_wrap;
  logic          stage_wrap;

  always_comb begin
    stages = cfg.stage_count;
    if (stages == 3'd0) begin
      stages = 3'd1;
    end else if (stages > 3'(MAX_STAGES)) begin
      stages = 3'(MAX_STAGES);
    end

    w_side = {1'b0, cfg.image_width};
    if (w_side == 14'd0) begin
      w_side = 14'd1;
    end else if (w_side > 14'(MAX_SIDE)) begin
      w_side = 14'(MAX_SIDE);
    end
    h_side = {1'b0, cfg.image_height};
    if (h_side == 14'd0) begin
      h_side = 14'd1;
    end else if (h_side > 14'(MAX_SIDE)) begin
      h_side = 14'(MAX_SIDE);
    end

    stage_eff = (stage >= 3'(MAX_STAGES)) ? 3'd0 : stage;
    shift     = stage_eff + 3'd3;
    stride    = 14'd1 << shift;
    cols      = (w_side + stride - 14'd1) >> shift;
    rows      = (h_side + stride - 14'd1) >> shift;

    col_wrap   = (14'(col) + 14'd1) >= cols;
    row_wrap   = (14'(row) + 14'd1) >= rows;
    stage_wrap = (stage_eff + 3'd1) >= stages;
    last       = col_wrap && row_wrap && stage_wrap;

    col_next   = col_wrap ? '0 : col + 1'b1;
    row_next   = row;
    stage_next = stage_eff;
    if (col_wrap) begin
      row_next = row_wrap ? '0 : row + 1'b1;
      if (row_wrap) begin
        stage_next = stage_wrap ? 3'd0 : stage_eff + 3'd1;
      end
    end
  end

  assign at_origin = (stage == 3'd0) && (row == '0) && (col == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= 3'd0;
      row   <= '0;
      col   <= '0;
    end else if (adv) begin
      stage <= stage_next;
      row   <= row_next;
      col   <= col_next;
    end
  end

endmodule

### hdl/afbd_calc.sv
// edge arithmetic: origin plus or minus scaled distance, then saturation
// depends on afbd_pkg
module afbd_calc #(
  parameter int CW = 9
) (
  input  logic               [2:0]  shift,
  input  logic               [CW-1:0] col,
  input  logic               [CW-1:0] row,
  input  logic               [15:0] threshold,
  input  logic               [15:0] score,
  input  logic signed        [15:0] dist_left,
  input  logic signed        [15:0] dist_top,
  input  logic signed        [15:0] dist_right,
  input  logic signed        [15:0] dist_bottom,
  output logic                      box_valid,
  output logic signed        [23:0] edge_x1,
  output logic signed        [23:0] edge_y1,
  output logic signed        [23:0] edge_x2,
  output logic signed        [23:0] edge_y2,
  output logic               [15:0] box_score
);

  logic        [3:0]  org_shift;
  logic signed [31:0] cx;
  logic signed [31:0] cy;
  logic signed [31:0] dl;
  logic signed [31:0] dt;
  logic signed [31:0] dr;
  logic signed [31:0] db;

  always_comb begin
    org_shift = {1'b0, shift} + 4'd8;
    cx = $signed(32'(col) << org_shift);
    cy = $signed(32'(row) << org_shift);
    dl = 32'(dist_left) <<< shift;
    dt = 32'(dist_top) <<< shift;
    dr = 32'(dist_right) <<< shift;
    db = 32'(dist_bottom) <<< shift;

    box_valid = score > threshold;
    if (box_valid) begin
      edge_x1   = afbd_pkg::sat24(cx - dl);
      edge_y1   = afbd_pkg::sat24(cy - dt);
      edge_x2   = afbd_pkg::sat24(cx + dr);
      edge_y2   = afbd_pkg::sat24(cy + db);
      box_score = score;
    end else begin
      edge_x1   = '0;
      edge_y1   = '0;
      edge_x2   = '0;
      edge_y2   = '0;
      box_score = '0;
    end
  end

endmodule
